### rtl/tcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal cursor control package
// Command codes, the internal operation set, queue entry and register
// write types shared by the front end, the execution unit and the top level.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Command codes as they arrive on the input stream.
  localparam logic [4:0] CMD_CR      = 5'd0;
  localparam logic [4:0] CMD_BS      = 5'd1;
  localparam logic [4:0] CMD_TAB     = 5'd2;
  localparam logic [4:0] CMD_SAVE    = 5'd3;
  localparam logic [4:0] CMD_RESTORE = 5'd4;
  localparam logic [4:0] CMD_IND     = 5'd5;
  localparam logic [4:0] CMD_RI      = 5'd6;
  localparam logic [4:0] CMD_CUU     = 5'd7;
  localparam logic [4:0] CMD_CUD     = 5'd8;
  localparam logic [4:0] CMD_CUF     = 5'd9;
  localparam logic [4:0] CMD_CUB     = 5'd10;
  localparam logic [4:0] CMD_CNL     = 5'd11;
  localparam logic [4:0] CMD_CPL     = 5'd12;
  localparam logic [4:0] CMD_CHA     = 5'd13;
  localparam logic [4:0] CMD_CUP     = 5'd14;
  localparam logic [4:0] CMD_CHT     = 5'd15;
  localparam logic [4:0] CMD_CBT     = 5'd16;
  localparam logic [4:0] CMD_VPA     = 5'd17;
  localparam logic [4:0] CMD_STBM    = 5'd18;
  localparam logic [4:0] CMD_ORG_ON  = 5'd19;
  localparam logic [4:0] CMD_ORG_OFF = 5'd20;
  localparam logic [4:0] CMD_SU      = 5'd21;
  localparam logic [4:0] CMD_SD      = 5'd22;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Operations carried out by the execution unit. A tab is a CHT of one.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CR,
    OP_BS,
    OP_CHT,
    OP_SAVE,
    OP_RESTORE,
    OP_IND,
    OP_RI,
    OP_CUU,
    OP_CUD,
    OP_CUF,
    OP_CUB,
    OP_CNL,
    OP_CPL,
    OP_CHA,
    OP_CUP,
    OP_CBT,
    OP_VPA,
    OP_STBM,
    OP_ORG_ON,
    OP_ORG_OFF,
    OP_SU,
    OP_SD
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] count;      // first parameter with its default applied
    logic [15:0] second_m1;  // second parameter minus one, zero when defaulted
    logic        second_dflt;
  } q_entry_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [8:0]           data;
  } cfg_wr_t;

endpackage : tcc_pkg
`default_nettype wire

### rtl/tcc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal cursor control front end
// Classifies each incoming command into an operation, applies parameter
// defaults and the private-prefix rule, and pushes the result to the queue.
// ----------------------------------------------------------------------------
module tcc_front
  import tcc_pkg::*;
(
  input  wire logic [4:0]  cmd_i,
  input  wire logic [15:0] first_param_i,
  input  wire logic [15:0] second_param_i,
  input  wire logic        private_flag_i,
  output q_entry_t         entry_o
);

  always_comb begin
    entry_o.count       = (first_param_i == 16'd0) ? 16'd1 : first_param_i;
    entry_o.second_dflt = (second_param_i == 16'd0);
    entry_o.second_m1   = (second_param_i == 16'd0) ? 16'd0 : second_param_i - 16'd1;

    case (cmd_i)
      CMD_CR:      entry_o.op = OP_CR;
      CMD_BS:      entry_o.op = OP_BS;
      CMD_TAB: begin
        // A plain tab is a forward tabulation by one stop.
        entry_o.op    = OP_CHT;
        entry_o.count = 16'd1;
      end
      CMD_SAVE:    entry_o.op = OP_SAVE;
      CMD_RESTORE: entry_o.op = OP_RESTORE;
      CMD_IND:     entry_o.op = OP_IND;
      CMD_RI:      entry_o.op = OP_RI;
      CMD_CUU:     entry_o.op = OP_CUU;
      CMD_CUD:     entry_o.op = OP_CUD;
      CMD_CUF:     entry_o.op = OP_CUF;
      CMD_CUB:     entry_o.op = OP_CUB;
      CMD_CNL:     entry_o.op = OP_CNL;
      CMD_CPL:     entry_o.op = OP_CPL;
      CMD_CHA:     entry_o.op = OP_CHA;
      CMD_CUP:     entry_o.op = OP_CUP;
      CMD_CHT:     entry_o.op = OP_CHT;
      CMD_CBT:     entry_o.op = OP_CBT;
      CMD_VPA:     entry_o.op = OP_VPA;
      CMD_STBM:    entry_o.op = private_flag_i ? OP_NOP : OP_STBM;
      CMD_ORG_ON:  entry_o.op = OP_ORG_ON;
      CMD_ORG_OFF: entry_o.op = OP_ORG_OFF;
      CMD_SU:      entry_o.op = private_flag_i ? OP_NOP : OP_SU;
      CMD_SD:      entry_o.op = private_flag_i ? OP_NOP : OP_SD;
      default:     entry_o.op = OP_NOP;
    endcase
  end

endmodule : tcc_front
`default_nettype wire

### rtl/tcc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal cursor control command queue
// Small register FIFO between the front end and the execution unit.
// ----------------------------------------------------------------------------
module tcc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule : tcc_queue
`default_nettype wire

### rtl/tcc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal cursor control execution unit
// Holds cursor, saved position, margins and grid size, carries out one queued
// operation per cycle unless output or config stalls, and registers the result.
// ----------------------------------------------------------------------------
module tcc_back
  import tcc_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = 256,
  parameter int unsigned MAX_COLS  = 256,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_wr_t     cfg_i,
  input  wire logic        op_valid_i,
  output logic             op_ready_o,
  input  wire q_entry_t    entry_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [55:0]      out_data_o
);

  localparam int unsigned RowLim       = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int unsigned ColLim       = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int unsigned RstLastRow   = ((24 < RowLim) ? 24 : RowLim) - 1;
  localparam int unsigned RstLastCol   = ((80 < ColLim) ? 80 : ColLim) - 1;

  // Column to tab-stop index, worked out at elaboration.
  logic [7:0] col_div [256];
  for (genvar g = 0; g < 256; g++) begin : g_div
    assign col_div[g] = 8'(g / TAB_WIDTH);
  end

  logic [7:0]  row_q, row_d, col_q, col_d;
  logic [7:0]  row_sv_q, row_sv_d, col_sv_q, col_sv_d;
  logic [7:0]  top_q, top_d, bot_q, bot_d;
  logic        origin_q, origin_d;
  logic [7:0]  last_row_q, last_row_d, last_col_q, last_col_d;
  logic        out_valid_q;
  logic [55:0] out_data_q, out_data_d;

  logic        fire;
  logic        req;
  logic signed [16:0] amount;
  logic [15:0] n, nm1;
  logic [7:0]  lo, hi;
  logic [7:0]  k_fwd, k_back;
  logic [16:0] cht_sum;
  logic [21:0] cht_pos;
  logic [16:0] cup_sum;
  logic [15:0] stbm_bot_raw;
  logic [7:0]  stbm_top, stbm_bot;
  logic [7:0]  cfg_last;

  assign op_ready_o  = (!out_valid_q || out_ready_i) && !cfg_i.valid;
  assign fire        = op_valid_i && op_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign n      = entry_i.count;
  assign nm1    = entry_i.count - 16'd1;
  assign k_fwd  = col_div[col_q];
  assign k_back = (col_q != 8'd0) ? col_div[col_q - 8'd1] : 8'd0;
  assign cht_sum = 17'(k_fwd) + 17'(n);
  assign cht_pos = 22'(cht_sum) * 22'(TAB_WIDTH);
  assign cup_sum = 17'(nm1) + 17'(top_q);
  assign stbm_bot_raw = entry_i.second_dflt ? 16'(last_row_q) : entry_i.second_m1;
  assign stbm_top = (nm1 > 16'(last_row_q)) ? last_row_q : nm1[7:0];
  assign stbm_bot = (stbm_bot_raw > 16'(last_row_q)) ? last_row_q : stbm_bot_raw[7:0];

  // A size register of zero counts as one; above the limit counts as the limit.
  always_comb begin
    if (cfg_i.data == 9'd0) begin
      cfg_last = 8'd0;
    end else if (cfg_i.index == CFG_ROWS && cfg_i.data > 9'(RowLim)) begin
      cfg_last = 8'(RowLim - 1);
    end else if (cfg_i.index != CFG_ROWS && cfg_i.data > 9'(ColLim)) begin
      cfg_last = 8'(ColLim - 1);
    end else begin
      cfg_last = 8'(cfg_i.data - 9'd1);
    end
  end

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    row_sv_d   = row_sv_q;
    col_sv_d   = col_sv_q;
    top_d      = top_q;
    bot_d      = bot_q;
    origin_d   = origin_q;
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    req        = 1'b0;
    amount     = '0;
    lo         = origin_q ? top_q : 8'd0;
    hi         = origin_q ? bot_q : last_row_q;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ROWS: begin
          last_row_d = cfg_last;
          top_d      = 8'd0;
          bot_d      = cfg_last;
          row_d      = (row_q > cfg_last) ? cfg_last : row_q;
          row_sv_d   = (row_sv_q > cfg_last) ? cfg_last : row_sv_q;
        end
        CFG_COLS: begin
          last_col_d = cfg_last;
          col_d      = (col_q > cfg_last) ? cfg_last : col_q;
          col_sv_d   = (col_sv_q > cfg_last) ? cfg_last : col_sv_q;
        end
        default: ;
      endcase
    end else if (fire) begin
      case (entry_i.op)
        OP_CR: col_d = 8'd0;
        OP_BS: col_d = (col_q != 8'd0) ? col_q - 8'd1 : 8'd0;
        OP_CHT: col_d = (cht_pos > 22'(last_col_q)) ? last_col_q : cht_pos[7:0];
        OP_SAVE: begin
          row_sv_d = row_q;
          col_sv_d = col_q;
        end
        OP_RESTORE: begin
          row_d = row_sv_q;
          col_d = col_sv_q;
        end
        OP_IND: begin
          if (row_q == bot_q) begin
            req    = 1'b1;
            amount = 17'sd1;
          end else if (row_q < last_row_q) begin
            row_d = row_q + 8'd1;
          end
        end
        OP_RI: begin
          if (row_q == top_q) begin
            req    = 1'b1;
            amount = -17'sd1;
          end else if (row_q != 8'd0) begin
            row_d = row_q - 8'd1;
          end
        end
        OP_CUU: row_d = (17'(row_q) < 17'(lo) + 17'(n)) ? lo : row_q - n[7:0];
        OP_CUD: row_d = (17'(row_q) + 17'(n) > 17'(hi)) ? hi : row_q + n[7:0];
        OP_CUF: col_d = (17'(col_q) + 17'(n) > 17'(last_col_q)) ? last_col_q
                                                                : col_q + n[7:0];
        OP_CUB: col_d = (16'(col_q) < n) ? 8'd0 : col_q - n[7:0];
        OP_CNL: begin
          row_d = (17'(row_q) + 17'(n) > 17'(bot_q)) ? bot_q : row_q + n[7:0];
          col_d = 8'd0;
        end
        OP_CPL: begin
          row_d = (17'(row_q) < 17'(top_q) + 17'(n)) ? top_q : row_q - n[7:0];
          col_d = 8'd0;
        end
        OP_CHA: col_d = (nm1 > 16'(last_col_q)) ? last_col_q : nm1[7:0];
        OP_CUP: begin
          if (origin_q) begin
            row_d = (cup_sum > 17'(bot_q)) ? bot_q : cup_sum[7:0];
          end else begin
            row_d = (nm1 > 16'(last_row_q)) ? last_row_q : nm1[7:0];
          end
          col_d = (entry_i.second_m1 > 16'(last_col_q)) ? last_col_q
                                                        : entry_i.second_m1[7:0];
        end
        OP_CBT: begin
          if (16'(k_back) >= nm1) begin
            col_d = 8'((12'(k_back) - 12'(nm1[7:0])) * 12'(TAB_WIDTH));
          end else begin
            col_d = 8'd0;
          end
        end
        OP_VPA: row_d = (nm1 > 16'(last_row_q)) ? last_row_q : nm1[7:0];
        OP_STBM: begin
          // The margins only move for a region of at least two rows.
          if (stbm_top < stbm_bot) begin
            top_d = stbm_top;
            bot_d = stbm_bot;
          end
          row_d = origin_q ? top_d : 8'd0;
          col_d = 8'd0;
        end
        OP_ORG_ON: begin
          origin_d = 1'b1;
          row_d    = top_q;
          col_d    = 8'd0;
        end
        OP_ORG_OFF: begin
          origin_d = 1'b0;
          row_d    = 8'd0;
          col_d    = 8'd0;
        end
        OP_SU: begin
          req    = 1'b1;
          amount = $signed({1'b0, n});
        end
        OP_SD: begin
          req    = 1'b1;
          amount = -$signed({1'b0, n});
        end
        default: ;
      endcase
    end

    out_data_d = {6'd0, amount, req, bot_d, top_d, col_d, row_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= 8'd0;
      col_q       <= 8'd0;
      row_sv_q    <= 8'd0;
      col_sv_q    <= 8'd0;
      top_q       <= 8'd0;
      bot_q       <= 8'(RstLastRow);
      origin_q    <= 1'b0;
      last_row_q  <= 8'(RstLastRow);
      last_col_q  <= 8'(RstLastCol);
      out_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      row_sv_q   <= row_sv_d;
      col_sv_q   <= col_sv_d;
      top_q      <= top_d;
      bot_q      <= bot_d;
      origin_q   <= origin_d;
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule : tcc_back
`default_nettype wire

### rtl/terminal_cursor_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Terminal cursor control
// VT-style cursor and scroll-margin engine: one decoded command in, the new
// cursor, margins and an optional region-scroll request out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         one command: tuser kind and flag, tdata parameters
//  m_axis    out        one result per command: cursor, margins, scroll
//  cfg       in         write of the row or column count register
//
//  One command per cycle sustained while m_axis is not stalled and no
//  configuration write is pending. A command taken is stored in the queue,
//  then carried out by the execution unit, and its result is held in the
//  output register and offered on m_axis until it is taken.
//  Reset gives a 24 by 80 grid, cursor at the origin, full-screen margins.
//  A two-entry queue separates the input from the execution unit, so two
//  further commands are taken while a result waits on the output. A
//  configuration write holds the execution unit for its cycle.
// ----------------------------------------------------------------------------
module terminal_cursor_control
  import tcc_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = 256,
  parameter int unsigned MAX_COLS  = 256,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: first_param [15:0], second_param [31:16]
  input  wire logic [31:0]          s_axis_tdata,
  // tuser: cmd [4:0], private_flag [5]
  input  wire logic [5:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: cursor_row [7:0], cursor_col [15:8], margin_top [23:16],
  // margin_bottom [31:24], scroll_request [32], scroll_amount [49:33]
  output logic [55:0]               m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [8:0]           cfg_data_i
);

  localparam int unsigned EntryW = $bits(q_entry_t);

  q_entry_t          front_entry;
  q_entry_t          back_entry;
  logic [EntryW-1:0] pop_data;
  logic              pop_valid, pop_ready;
  cfg_wr_t           cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;
  assign back_entry   = q_entry_t'(pop_data);

  tcc_front u_front (
    .cmd_i          (s_axis_tuser[4:0]),
    .first_param_i  (s_axis_tdata[15:0]),
    .second_param_i (s_axis_tdata[31:16]),
    .private_flag_i (s_axis_tuser[5]),
    .entry_o        (front_entry)
  );

  tcc_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (front_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tcc_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .op_valid_i  (pop_valid),
    .op_ready_o  (pop_ready),
    .entry_i     (back_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule : terminal_cursor_control
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Terminal cursor control testbench
// Drives decoded commands into the cursor engine under random input gaps and
// output stalls. A behavioural model of the cursor, margins and origin mode
// predicts every result, which is checked field by field. Covers every
// command code, the grid size extremes and a back-to-back finish.
// ----------------------------------------------------------------------------
module testbench;
  import tcc_pkg::*;

  localparam int TAB_STOP    = 8;
  localparam int GRID_LIMIT  = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;

  // Packed so that the cast from the output tdata lines up, row in the low bits.
  typedef struct packed {
    logic signed [16:0] amount;
    logic               scroll;
    logic [7:0]         bottom;
    logic [7:0]         top;
    logic [7:0]         col;
    logic [7:0]         row;
  } cursor_view_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [5:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [8:0] cfg_data_i;

  // Model of the engine state.
  int unsigned rows_reg, cols_reg;
  int row_q, col_q, mark_row, mark_col, top_q, bottom_q;
  bit origin_q;

  cursor_view_t expected_cursor_q[$];
  cursor_view_t seen_view, wanted_view;

  bit idle_on, stall_on;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  int error_count = 0;
  int results_checked = 0;
  int commands_sent, grid_settings;

  terminal_cursor_control dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int grid_size(input int unsigned reg_value);
    int v;
    v = int'(reg_value & 9'h1FF);
    if (v < 1) v = 1;
    if (v > GRID_LIMIT) v = GRID_LIMIT;
    return v;
  endfunction

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one command to the model state and returns the view it reports.
  function automatic cursor_view_t advance_cursor(input logic [4:0] cmd,
                                                  input logic [15:0] first_p,
                                                  input logic [15:0] second_p,
                                                  input logic priv);
    cursor_view_t view;
    int last_row, last_col, n, r, c, k;
    bit req;
    int amount;
    last_row = grid_size(rows_reg) - 1;
    last_col = grid_size(cols_reg) - 1;
    n = (first_p == 16'd0) ? 1 : int'(first_p);
    req = 1'b0;
    amount = 0;
    case (cmd)
      CMD_CR: col_q = 0;
      CMD_BS: col_q = (col_q > 0) ? col_q - 1 : 0;
      CMD_TAB: col_q = clamp_to((col_q / TAB_STOP + 1) * TAB_STOP, 0, last_col);
      CMD_SAVE: begin
        mark_row = row_q;
        mark_col = col_q;
      end
      CMD_RESTORE: begin
        row_q = mark_row;
        col_q = mark_col;
      end
      CMD_IND: begin
        if (row_q == bottom_q) begin
          req = 1'b1;
          amount = 1;
        end else if (row_q < last_row) begin
          row_q++;
        end
      end
      CMD_RI: begin
        if (row_q == top_q) begin
          req = 1'b1;
          amount = -1;
        end else if (row_q > 0) begin
          row_q--;
        end
      end
      CMD_CUU: begin
        r = row_q - n;
        row_q = (r < (origin_q ? top_q : 0)) ? (origin_q ? top_q : 0) : r;
      end
      CMD_CUD: begin
        r = row_q + n;
        row_q = (r > (origin_q ? bottom_q : last_row)) ? (origin_q ? bottom_q : last_row) : r;
      end
      CMD_CUF: col_q = (col_q + n > last_col) ? last_col : col_q + n;
      CMD_CUB: col_q = (col_q - n < 0) ? 0 : col_q - n;
      // Next and previous line clamp to the margins even from outside them.
      CMD_CNL: begin
        r = row_q + n;
        row_q = (r > bottom_q) ? bottom_q : r;
        col_q = 0;
      end
      CMD_CPL: begin
        r = row_q - n;
        row_q = (r < top_q) ? top_q : r;
        col_q = 0;
      end
      CMD_CHA: col_q = clamp_to(n - 1, 0, last_col);
      CMD_CUP: begin
        c = ((second_p == 16'd0) ? 1 : int'(second_p)) - 1;
        if (origin_q) row_q = clamp_to(n - 1 + top_q, top_q, bottom_q);
        else row_q = clamp_to(n - 1, 0, last_row);
        col_q = clamp_to(c, 0, last_col);
      end
      CMD_CHT: begin
        c = (col_q / TAB_STOP + n) * TAB_STOP;
        col_q = (c > last_col) ? last_col : c;
      end
      CMD_CBT: begin
        k = (col_q > 0) ? (col_q - 1) / TAB_STOP : 0;
        col_q = (k >= n - 1) ? (k - (n - 1)) * TAB_STOP : 0;
      end
      CMD_VPA: row_q = clamp_to(n - 1, 0, last_row);
      CMD_STBM: begin
        if (!priv) begin
          r = clamp_to(n - 1, 0, last_row);
          c = clamp_to(((second_p == 16'd0) ? last_row + 1 : int'(second_p)) - 1,
                       0, last_row);
          if (r < c) begin
            top_q = r;
            bottom_q = c;
          end
          row_q = origin_q ? top_q : 0;
          col_q = 0;
        end
      end
      CMD_ORG_ON: begin
        origin_q = 1'b1;
        row_q = top_q;
        col_q = 0;
      end
      CMD_ORG_OFF: begin
        origin_q = 1'b0;
        row_q = 0;
        col_q = 0;
      end
      CMD_SU: begin
        if (!priv) begin
          req = 1'b1;
          amount = n;
        end
      end
      CMD_SD: begin
        if (!priv) begin
          req = 1'b1;
          amount = -n;
        end
      end
      default: ;
    endcase
    view.row    = row_q[7:0];
    view.col    = col_q[7:0];
    view.top    = top_q[7:0];
    view.bottom = bottom_q[7:0];
    view.scroll = req;
    view.amount = amount[16:0];
    return view;
  endfunction

  function automatic logic [15:0] pick_param();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1, 2, 3, 4, 5: return 16'($urandom_range(1, 12));
      6, 7: return 16'($urandom_range(1, 300));
      8: return 16'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic send_command(input logic [4:0] cmd, input logic [15:0] first_p,
                              input logic [15:0] second_p, input logic priv);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second_p, first_p};
    s_axis_tuser  <= {priv, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_cursor_q.insert(expected_cursor_q.size(),
                             advance_cursor(cmd, first_p, second_p, priv));
    commands_sent++;
  endtask

  // Leaves the engine idle with nothing outstanding.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_cursor_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write request raised; the caller drops it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [8:0] value);
    int last;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_ROWS) begin
      rows_reg = value;
      last = grid_size(rows_reg) - 1;
      top_q = 0;
      bottom_q = last;
      row_q = clamp_to(row_q, 0, last);
      mark_row = clamp_to(mark_row, 0, last);
    end else if (index == CFG_COLS) begin
      cols_reg = value;
      last = grid_size(cols_reg) - 1;
      col_q = clamp_to(col_q, 0, last);
      mark_col = clamp_to(mark_col, 0, last);
    end
  endtask

  task automatic set_grid(input logic [8:0] rows, input logic [8:0] cols);
    drain_results();
    write_register(CFG_ROWS, rows);
    write_register(CFG_COLS, cols);
    cfg_valid_i <= 1'b0;
    grid_settings++;
  endtask

  task automatic send_random_commands(input int count);
    logic [4:0] cmd;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) cmd = 5'($urandom_range(23, 31));
      else cmd = 5'($urandom_range(0, 22));
      send_command(cmd, pick_param(), pick_param(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic note_mismatch(input string field, input logic signed [31:0] wanted_v,
                               input logic signed [31:0] seen_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted_v, seen_v);
    error_count++;
  endtask

  // Output side: random stalls, result checking and the run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               expected_cursor_q.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        seen_view = cursor_view_t'(m_axis_tdata[49:0]);
        if (expected_cursor_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          wanted_view = expected_cursor_q.pop_front();
          results_checked++;
          if (seen_view.row !== wanted_view.row)
            note_mismatch("cursor_row", wanted_view.row, seen_view.row);
          if (seen_view.col !== wanted_view.col)
            note_mismatch("cursor_col", wanted_view.col, seen_view.col);
          if (seen_view.top !== wanted_view.top)
            note_mismatch("margin_top", wanted_view.top, seen_view.top);
          if (seen_view.bottom !== wanted_view.bottom)
            note_mismatch("margin_bottom", wanted_view.bottom, seen_view.bottom);
          if (seen_view.scroll !== wanted_view.scroll)
            note_mismatch("scroll_request", wanted_view.scroll, seen_view.scroll);
          if (seen_view.amount !== wanted_view.amount)
            note_mismatch("scroll_amount", wanted_view.amount, seen_view.amount);
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_reset_view();
    // Unused codes report the state untouched, here the state after reset.
    send_command(5'd23, 16'd0, 16'd0, 1'b0);
    send_command(5'd31, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_edges_and_tabs();
    send_command(CMD_CUP, 16'd0, 16'd0, 1'b0);
    send_command(CMD_CUP, 16'hFFFF, 16'hFFFF, 1'b0);
    send_command(CMD_TAB, 16'd0, 16'd0, 1'b0);
    send_command(CMD_CR, 16'd0, 16'd0, 1'b0);
    send_command(CMD_CHT, 16'd3, 16'd0, 1'b0);
    send_command(CMD_CBT, 16'hFFFF, 16'd0, 1'b0);
    send_command(CMD_CHT, 16'hFFFF, 16'd0, 1'b0);
    send_command(CMD_CBT, 16'd2, 16'd0, 1'b0);
    send_command(CMD_BS, 16'd0, 16'd0, 1'b0);
    send_command(CMD_SAVE, 16'd0, 16'd0, 1'b0);
  endtask

  task automatic test_margins_and_origin();
    send_command(CMD_STBM, 16'd5, 16'd20, 1'b0);
    send_command(CMD_STBM, 16'd1, 16'd10, 1'b1);
    send_command(CMD_STBM, 16'd10, 16'd5, 1'b0);
    send_command(CMD_ORG_ON, 16'd0, 16'd0, 1'b1);
    send_command(CMD_CUU, 16'hFFFF, 16'd0, 1'b0);
    send_command(CMD_CUD, 16'hFFFF, 16'd0, 1'b0);
    send_command(CMD_ORG_OFF, 16'd0, 16'd0, 1'b1);
    // From above the top margin, a previous-line move lands on the margin.
    send_command(CMD_CNL, 16'd2, 16'd0, 1'b0);
    send_command(CMD_CPL, 16'd1, 16'd0, 1'b0);
    send_command(CMD_RESTORE, 16'd0, 16'd0, 1'b0);
  endtask

  task automatic test_scroll_requests();
    send_command(CMD_CUP, 16'd20, 16'd1, 1'b0);
    send_command(CMD_IND, 16'd0, 16'd0, 1'b0);
    send_command(CMD_CUP, 16'd5, 16'd1, 1'b0);
    send_command(CMD_RI, 16'd0, 16'd0, 1'b0);
    send_command(CMD_SU, 16'd0, 16'd0, 1'b0);
    send_command(CMD_SD, 16'hFFFF, 16'd0, 1'b0);
    send_command(CMD_SU, 16'd7, 16'd0, 1'b1);
    send_command(CMD_STBM, 16'd0, 16'd0, 1'b0);
  endtask

  task automatic test_grid_sizes();
    set_grid(9'd0, 9'd0);
    send_random_commands(150);
    set_grid(9'd1, 9'd1);
    send_random_commands(150);
    set_grid(9'd2, 9'd9);
    send_random_commands(150);
    set_grid(9'd511, 9'd511);
    send_random_commands(150);
    set_grid(9'd256, 9'd256);
    send_random_commands(150);
    set_grid(9'd13, 9'd300);
    send_random_commands(150);
    set_grid(9'd40, 9'd132);
    send_random_commands(150);
  endtask

  task automatic test_random_traffic();
    set_grid(9'd24, 9'd80);
    send_random_commands(550);
  endtask

  task automatic test_back_to_back();
    set_grid(9'd25, 9'd17);
    idle_on = 1'b0;
    stall_on = 1'b0;
    send_random_commands(200);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROWS;
    cfg_data_i = '0;
    rows_reg = 24;
    cols_reg = 80;
    row_q = 0;
    col_q = 0;
    mark_row = 0;
    mark_col = 0;
    top_q = 0;
    bottom_q = grid_size(rows_reg) - 1;
    origin_q = 1'b0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    commands_sent = 0;
    grid_settings = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_edges_and_tabs();
    test_margins_and_origin();
    test_scroll_requests();
    test_grid_sizes();
    test_random_traffic();
    test_back_to_back();
    drain_results();

    $display("Ran %0d commands and checked %0d results over %0d grid sizes,", commands_sent,
             results_checked, grid_settings);
    $display("with random input gaps and output stalls, then a back-to-back stretch.");
    if (error_count == 0 && expected_cursor_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tcc_pkg.sv
rtl/tcc_front.sv
rtl/tcc_queue.sv
rtl/tcc_back.sv
rtl/terminal_cursor_control.sv
sim/testbench.sv
